@@ design/detection_iou_greedy_matcher_defines.svh @@
// assertion helpers for the matcher
`ifndef DETECTION_IOU_GREEDY_MATCHER_DEFINES_SVH
`define DETECTION_IOU_GREEDY_MATCHER_DEFINES_SVH

// property that holds whenever reset is released
`define DIGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication on the next cycle
`define DIGM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/digm_pkg.sv @@
package digm_pkg;

  localparam int unsigned FuncW = 2;
  localparam logic [1:0] FuncTruth = 2'd0;
  localparam logic [1:0] FuncGuess = 2'd1;
  localparam logic [1:0] FuncEnd   = 2'd2;

  localparam int unsigned ClassW = 8;
  localparam int unsigned ConfW  = 17;
  localparam int unsigned IouW   = 16;
  localparam int unsigned GtIdxW = 6;
  localparam int unsigned CoordW = 14;

  // area fits in 2*(CoordW+1)+2 bits, times 2^16 for the quotient
  localparam int unsigned AreaW = 2 * (CoordW + 1) + 2;
  localparam int unsigned NumW  = AreaW + IouW;

  typedef struct packed {
    logic [ClassW-1:0] pred_class;
    logic [ConfW-1:0]  pred_conf;
    logic [IouW-1:0]   match_iou;
    logic [GtIdxW-1:0] matched_gt;
    logic              nothing_detected;
    logic              overflow;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [ClassW-1:0] class_id;
    logic [ConfW-1:0]  confidence;
    logic [CoordW-1:0] left_x;
    logic [CoordW-1:0] top_y;
    logic [CoordW-1:0] right_x;
    logic [CoordW-1:0] bottom_y;
  } item_t;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [AreaW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

@@ design/digm_if.sv @@
interface digm_in_if import digm_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface digm_out_if import digm_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/digm_ram.sv @@
module digm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ design/digm_div.sv @@
module digm_div import digm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  quot_q, quot_d;
  logic [AreaW:0]   rem_q, rem_d;
  logic [AreaW-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [AreaW:0]   trial;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[AreaW-1:0], quot_q[NumW-1]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule

@@ design/detection_iou_greedy_matcher.sv @@
// greedy iou matcher for one image of detections
// input channel in_i: func 0 loads a ground-truth box, func 1 a prediction box,
// func 2 ends the image; func 3 is ignored.
// output channel out_o: one result per prediction, in descending confidence
// order (arrival order on ties), last set on the final one. an image without
// predictions gives a single result with nothing_detected set.
// at the end item the block walks: a selection pass over the n stored
// predictions (StSelRd and StSel for each) picks the next one, StGRd and
// StGLat fetch it, then every ground truth is scored through one shared
// restoring divider in StTRd, StGeom, StArea, StDiv and StWait, the divider
// being skipped when the boxes do not overlap, and StEmit posts the result.
// in_ready stays low during the walk and while a result waits.
// a finished result sits in an output register; while the receiver stalls,
// the walk holds at the emit step and resumes once the result is taken.
// reset clears counts, claimed bits and the overflow flag; the box memories
// need no clearing since only entries written in the current image are read.
module detection_iou_greedy_matcher
  import digm_pkg::*;
#(
  parameter int unsigned MAX_TRUTH = 64,
  parameter int unsigned MAX_GUESS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  digm_in_if.sink    in_i,
  digm_out_if.source out_o
);
  `include "detection_iou_greedy_matcher_defines.svh"

  localparam int unsigned TW  = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int unsigned GW  = (MAX_GUESS > 1) ? $clog2(MAX_GUESS) : 1;
  localparam int unsigned TCW = $clog2(MAX_TRUTH + 1);
  localparam int unsigned GCW = $clog2(MAX_GUESS + 1);
  localparam int unsigned BoxW = 4 * CoordW;
  localparam int unsigned TagW = ClassW + ConfW;
  localparam int unsigned SW = CoordW + 1;

  localparam logic [3:0] StLoad  = 4'd0;
  localparam logic [3:0] StSelRd = 4'd1;
  localparam logic [3:0] StSel   = 4'd2;
  localparam logic [3:0] StGRd   = 4'd3;
  localparam logic [3:0] StGLat  = 4'd4;
  localparam logic [3:0] StTRd   = 4'd5;
  localparam logic [3:0] StGeom  = 4'd6;
  localparam logic [3:0] StArea  = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StWait  = 4'd9;
  localparam logic [3:0] StEmit  = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] st_q, st_d;
  logic [TCW-1:0] tcnt_q;
  logic [GCW-1:0] gcnt_q;
  logic [MAX_TRUTH-1:0] claimed_q;
  logic [MAX_GUESS-1:0] done_q;
  logic drop_q;

  logic [GCW-1:0] scan_q;
  logic [GW-1:0]  bsel_q;
  logic [ConfW-1:0] bconf_q;
  logic           bvalid_q;
  logic [GCW-1:0] emitted_q;
  logic [TCW-1:0] tidx_q;
  logic [IouW-1:0] best_q;
  logic [TW-1:0]  bidx_q;
  logic [TagW-1:0] gtag_q;
  logic [BoxW-1:0] gbox_q;

  logic signed [SW:0] ov_w_q, ov_h_q;
  logic signed [SW:0] aw_q, ah_q, bw_q, bh_q;
  logic [AreaW-1:0] ov_q, ua_q, ub_q;

  result_t res_q;
  logic    ovalid_q;
  logic    set_valid;

  // memories
  logic tb_we, gb_we;
  logic [TW-1:0] tb_ra;
  logic [GW-1:0] gb_ra;
  logic [BoxW-1:0] tb_rd, gb_rd, in_box;
  logic [TagW-1:0] gt_rd;

  assign in_box = {in_i.data.left_x, in_i.data.top_y, in_i.data.right_x, in_i.data.bottom_y};

  logic acc;
  assign in_i.ready = (st_q == StLoad) && !ovalid_q;
  assign acc = in_i.valid && in_i.ready;
  assign tb_we = acc && in_i.data.func == FuncTruth && tcnt_q < TCW'(MAX_TRUTH);
  assign gb_we = acc && in_i.data.func == FuncGuess && gcnt_q < GCW'(MAX_GUESS);

  digm_ram #(.Width(BoxW), .Depth(MAX_TRUTH)) u_truth (
    .clk_i, .we_i(tb_we), .waddr_i(tcnt_q[TW-1:0]), .wdata_i(in_box),
    .raddr_i(tb_ra), .rdata_o(tb_rd));
  digm_ram #(.Width(BoxW), .Depth(MAX_GUESS)) u_gbox (
    .clk_i, .we_i(gb_we), .waddr_i(gcnt_q[GW-1:0]), .wdata_i(in_box),
    .raddr_i(gb_ra), .rdata_o(gb_rd));
  digm_ram #(.Width(TagW), .Depth(MAX_GUESS)) u_gtag (
    .clk_i, .we_i(gb_we), .waddr_i(gcnt_q[GW-1:0]),
    .wdata_i({in_i.data.class_id, in_i.data.confidence}),
    .raddr_i(gb_ra), .rdata_o(gt_rd));

  assign tb_ra = tidx_q[TW-1:0];
  assign gb_ra = (st_q == StSelRd || st_q == StSel) ? scan_q[GW-1:0] : bsel_q;

  div_req_t dreq;
  div_rsp_t drsp;
  digm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // box field decode
  function automatic logic signed [SW:0] fx(input logic [BoxW-1:0] b, input int k);
    logic [CoordW-1:0] c;
    c = b[BoxW-1-k*CoordW -: CoordW];
    return (SW+1)'(signed'(c));
  endfunction

  logic signed [SW:0] x1, y1, x2, y2;
  logic signed [SW:0] tl, tt, tr, tbm, gl, gt, gr, gbm;
  always_comb begin
    tl = fx(tb_rd, 0); tt = fx(tb_rd, 1); tr = fx(tb_rd, 2); tbm = fx(tb_rd, 3);
    gl = fx(gbox_q, 0); gt = fx(gbox_q, 1); gr = fx(gbox_q, 2); gbm = fx(gbox_q, 3);
    x1 = (tl > gl) ? tl : gl;
    y1 = (tt > gt) ? tt : gt;
    x2 = (tr < gr) ? tr : gr;
    y2 = (tbm < gbm) ? tbm : gbm;
  end

  logic signed [AreaW-1:0] ova, uaa, uba;
  logic signed [AreaW:0] un;
  always_comb begin
    ova = AreaW'(ov_w_q * ov_h_q);
    uaa = AreaW'(aw_q * ah_q);
    uba = AreaW'(bw_q * bh_q);
    un = (AreaW+1)'(signed'(ua_q)) + (AreaW+1)'(signed'(ub_q)) - (AreaW+1)'(ov_q);
  end

  logic ov_zero;
  assign ov_zero = (ov_q == '0) || ov_w_q < 0 || ov_h_q < 0;

  always_comb begin
    dreq.start = (st_q == StDiv) && !ov_zero && (un > 0);
    dreq.num = {ov_q, {IouW{1'b0}}};
    dreq.den = un[AreaW-1:0];
  end

  logic last_pred;
  assign last_pred = (emitted_q + 1'b1) == gcnt_q;

  // a result is posted by an empty image end or by the emit step
  assign set_valid = (acc && in_i.data.func == FuncEnd && gcnt_q == '0) ||
                     (st_q == StEmit && (!ovalid_q || out_o.ready));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      tcnt_q <= '0;
      gcnt_q <= '0;
      claimed_q <= '0;
      done_q <= '0;
      drop_q <= 1'b0;
      ovalid_q <= 1'b0;
      emitted_q <= '0;
      scan_q <= '0;
      bvalid_q <= 1'b0;
      tidx_q <= '0;
    end else begin
      ovalid_q <= set_valid || (ovalid_q && !out_o.ready);
      case (st_q)
        StLoad: begin
          if (acc) begin
            case (in_i.data.func)
              FuncTruth: begin
                if (tb_we) tcnt_q <= tcnt_q + 1'b1;
                else drop_q <= 1'b1;
              end
              FuncGuess: begin
                if (gb_we) gcnt_q <= gcnt_q + 1'b1;
                else drop_q <= 1'b1;
              end
              FuncEnd: begin
                if (gcnt_q == '0) begin
                  res_q <= {{(ClassW + ConfW + IouW + GtIdxW){1'b0}}, 1'b1, drop_q, 1'b1};
                  tcnt_q <= '0;
                  drop_q <= 1'b0;
                  claimed_q <= '0;
                end else begin
                  scan_q <= '0;
                  bvalid_q <= 1'b0;
                  emitted_q <= '0;
                  done_q <= '0;
                  st_q <= StSelRd;
                end
              end
              default: ;
            endcase
          end
        end
        StSelRd: st_q <= StSel;
        StSel: begin
          // strict greater keeps arrival order among equal confidences
          if (!done_q[scan_q[GW-1:0]] &&
              (!bvalid_q || gt_rd[ConfW-1:0] > bconf_q)) begin
            bvalid_q <= 1'b1;
            bconf_q <= gt_rd[ConfW-1:0];
            bsel_q <= scan_q[GW-1:0];
          end
          if (scan_q + 1'b1 == gcnt_q) st_q <= StGRd;
          else begin
            scan_q <= scan_q + 1'b1;
            st_q <= StSelRd;
          end
        end
        StGRd: begin
          st_q <= StGLat;
        end
        StGLat: begin
          gbox_q <= gb_rd;
          gtag_q <= gt_rd;
          done_q[bsel_q] <= 1'b1;
          tidx_q <= '0;
          best_q <= '0;
          bidx_q <= '0;
          st_q <= (tcnt_q == '0) ? StEmit : StTRd;
        end
        StTRd: st_q <= StGeom;
        StGeom: begin
          ov_w_q <= x2 - x1;
          ov_h_q <= y2 - y1;
          aw_q <= tr - tl;
          ah_q <= tbm - tt;
          bw_q <= gr - gl;
          bh_q <= gbm - gt;
          st_q <= StArea;
        end
        StArea: begin
          ov_q <= ova;
          ua_q <= uaa;
          ub_q <= uba;
          st_q <= StDiv;
        end
        StDiv: st_q <= StWait;
        StWait: begin
          if (!(ov_zero || un <= 0) && !drsp.done) begin
            st_q <= StWait;
          end else begin
            logic [IouW-1:0] v;
            v = (ov_zero || un <= 0) ? '0 :
                ((drsp.quot > NumW'(16'hFFFF)) ? 16'hFFFF : drsp.quot[IouW-1:0]);
            if (tidx_q == '0 || v > best_q) begin
              best_q <= v;
              bidx_q <= tidx_q[TW-1:0];
            end
            if (tidx_q + 1'b1 == tcnt_q) st_q <= StEmit;
            else begin
              tidx_q <= tidx_q + 1'b1;
              st_q <= StTRd;
            end
          end
        end
        StEmit: begin
          if (!ovalid_q || out_o.ready) begin
            res_q.pred_class <= gtag_q[TagW-1:ConfW];
            res_q.pred_conf <= gtag_q[ConfW-1:0];
            res_q.match_iou <= (tcnt_q != '0 && !claimed_q[bidx_q]) ? best_q : '0;
            res_q.matched_gt <= GtIdxW'({{GtIdxW{1'b0}}, bidx_q});
            res_q.nothing_detected <= 1'b0;
            res_q.overflow <= drop_q;
            res_q.last <= last_pred;
            if (tcnt_q != '0) claimed_q[bidx_q] <= 1'b1;
            emitted_q <= emitted_q + 1'b1;
            if (last_pred) begin
              st_q <= StLoad;
              tcnt_q <= '0;
              gcnt_q <= '0;
              drop_q <= 1'b0;
              claimed_q <= '0;
            end else begin
              scan_q <= '0;
              bvalid_q <= 1'b0;
              st_q <= StSelRd;
            end
          end
        end
        default: st_q <= StLoad;
      endcase
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data = res_q;

  `DIGM_ASSERT(a_ready_idle, !(in_i.ready && st_q != StLoad), "ready outside load state")
  `DIGM_ASSERT(a_cnt_range, gcnt_q <= GCW'(MAX_GUESS), "guess count beyond capacity")
  `DIGM_ASSERT_NEXT(a_hold, out_o.valid && !out_o.ready, out_o.valid,
                    "result dropped while stalled")
endmodule
